// ===== rtl/cursor_mask_to_rgba_outline_core_defines.svh =====
// Assertion macros used by the checker file of the cursor outline core.
`ifndef CURSOR_MASK_TO_RGBA_OUTLINE_CORE_DEFINES_SVH
`define CURSOR_MASK_TO_RGBA_OUTLINE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMRO_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cursor outline core check failed");

// The consequent must hold in the cycle after the antecedent.
`define CMRO_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cursor outline core check failed");

`endif

// ===== rtl/cmro_pkg.sv =====
// Types, codes and helper functions of the cursor outline core.
package cmro_pkg;

  typedef logic [1:0] code_t;

  localparam code_t CODE_CLEAR = 2'd0;
  localparam code_t CODE_BLACK = 2'd1;
  localparam code_t CODE_WHITE = 2'd2;
  localparam code_t CODE_XOR   = 2'd3;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam int CFG_IDX_W = 1;
  localparam int DIM_W     = 7;
  localparam int COORD_W   = 7;
  localparam int BYTE_W    = 8;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [BYTE_W-1:0]    byte_t;

  localparam cfg_idx_t REG_CURSOR_WIDTH  = 1'd0;
  localparam cfg_idx_t REG_CURSOR_HEIGHT = 1'd1;

  localparam dim_t DIM_RESET = 7'd32;

  localparam byte_t BYTE_FULL = 8'hff;
  localparam byte_t BYTE_NONE = 8'h00;

  function automatic code_t load_code(input logic and_bit, input logic xor_bit);
    code_t c;
    if (!and_bit) begin
      c = xor_bit ? CODE_WHITE : CODE_BLACK;
    end else begin
      c = xor_bit ? CODE_XOR : CODE_CLEAR;
    end
    return c;
  endfunction

  function automatic byte_t code_color(input code_t c);
    return (c == CODE_WHITE) ? BYTE_FULL : BYTE_NONE;
  endfunction

  function automatic byte_t code_alpha(input code_t c);
    return (c != CODE_CLEAR) ? BYTE_FULL : BYTE_NONE;
  endfunction

endpackage

// ===== rtl/cmro_ifs.sv =====
// Channel interfaces of the cursor outline core: request, response and register write.
interface cmro_req_if;
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic                 and_bit;
  logic                 xor_bit;
  cmro_pkg::coord_t     col;
  cmro_pkg::coord_t     row;
  modport source (output valid, func, and_bit, xor_bit, col, row, input ready);
  modport sink (input valid, func, and_bit, xor_bit, col, row, output ready);
endinterface

interface cmro_rsp_if;
  logic                 valid;
  logic                 ready;
  cmro_pkg::byte_t      red;
  cmro_pkg::byte_t      green;
  cmro_pkg::byte_t      blue;
  cmro_pkg::byte_t      alpha;
  logic                 outline_needed;
  modport source (output valid, red, green, blue, alpha, outline_needed, input ready);
  modport sink (input valid, red, green, blue, alpha, outline_needed, output ready);
endinterface

interface cmro_cfg_if;
  logic                 valid;
  logic                 ready;
  cmro_pkg::cfg_idx_t   index;
  cmro_pkg::dim_t       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/cmro_code_store.sv =====
// Pixel code memory with one write port and one registered read port.
module cmro_code_store #(
  parameter int ADDR_W = 12
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  cmro_pkg::code_t      wr_code,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output cmro_pkg::code_t      rd_code
);

  cmro_pkg::code_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_code <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/cursor_mask_to_rgba_outline_core.sv =====
// Top level of the AND/XOR cursor to RGBA converter with white outline.
//
//   channel | role         | payload
//   --------+--------------+-----------------------------------------------
//   cfg     | register in  | index, data (cursor width or height)
//   req     | item in      | func, and_bit, xor_bit, col, row
//   rsp     | result out   | red, green, blue, alpha, outline_needed
//
// A load or a read outside the padded frame is registered in the result holding register, then
// moves to the output register once that is free. A read inside the padded frame scans nine
// neighbor positions through the single read port of the pixel memory, waits for the registered
// read data and finishes in the drain state. The input waits until the result has moved to the
// output register, so no request is taken while one is in progress; a stalled output holds it longer.
// Reset clears control state, the outline flag and the size registers, not the pixel memory.
module cursor_mask_to_rgba_outline_core #(
  parameter int MAX_DIM = 64
) (
  input  logic       clk,
  input  logic       rst,
  cmro_cfg_if.sink   cfg,
  cmro_req_if.sink   req,
  cmro_rsp_if.source rsp
);

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int CMP_W  = ((IDX_W + 1 > cmro_pkg::COORD_W) ? IDX_W + 1 : cmro_pkg::COORD_W) + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]        state;
  cmro_pkg::dim_t    cursor_width;
  cmro_pkg::dim_t    cursor_height;
  logic              xor_seen;
  cmro_pkg::coord_t  rd_col;
  cmro_pkg::coord_t  rd_row;
  logic [1:0]        kx;
  logic [1:0]        ky;
  logic              pend;
  logic              pend_inb;
  logic              pend_ctr;
  cmro_pkg::code_t   center;
  logic              near;
  logic              res_pend;
  cmro_pkg::code_t   res_code;
  logic              res_flag;
  logic              out_valid;
  cmro_pkg::code_t   out_code;
  logic              out_flag;

  logic [CMP_W-1:0]  w;
  logic [CMP_W-1:0]  h;
  logic [CMP_W-1:0]  req_col;
  logic [CMP_W-1:0]  req_row;
  logic [CMP_W-1:0]  px;
  logic [CMP_W-1:0]  py;
  logic              scan_inb;
  logic              req_take;
  logic              load_take;
  logic              read_take;
  logic              load_inb;
  logic              read_outside;
  cmro_pkg::code_t   new_code;
  logic              flag_next;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  cmro_pkg::code_t   rd_code;
  cmro_pkg::code_t   cur_code;
  cmro_pkg::code_t   center_now;
  logic              near_now;
  cmro_pkg::code_t   read_result;
  logic              out_load;

  assign w = (CMP_W'(cursor_width) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : CMP_W'(cursor_width);
  assign h = (CMP_W'(cursor_height) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : CMP_W'(cursor_height);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_width  <= cmro_pkg::DIM_RESET;
      cursor_height <= cmro_pkg::DIM_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        cmro_pkg::REG_CURSOR_WIDTH:  cursor_width  <= cfg.data;
        cmro_pkg::REG_CURSOR_HEIGHT: cursor_height <= cfg.data;
        default: ;
      endcase
    end
  end

  assign req.ready    = (state == ST_IDLE) && !res_pend;
  assign req_take     = req.valid && req.ready;
  assign load_take    = req_take && (req.func == cmro_pkg::FUNC_LOAD);
  assign read_take    = req_take && (req.func == cmro_pkg::FUNC_READ);
  assign req_col      = CMP_W'(req.col);
  assign req_row      = CMP_W'(req.row);
  assign load_inb     = (req_col < w) && (req_row < h);
  assign read_outside = (req_col >= w + CMP_W'(2)) || (req_row >= h + CMP_W'(2));
  assign new_code     = cmro_pkg::load_code(req.and_bit, req.xor_bit);

  always_comb begin
    flag_next = ((req.col == '0) && (req.row == '0)) ? 1'b0 : xor_seen;
    if (new_code == cmro_pkg::CODE_XOR) begin
      flag_next = 1'b1;
    end
  end

  assign wr_en   = load_take && load_inb;
  assign wr_addr = {IDX_W'(req.row), IDX_W'(req.col)};

  assign px       = CMP_W'(rd_col) + CMP_W'(kx);
  assign py       = CMP_W'(rd_row) + CMP_W'(ky);
  assign scan_inb = (px >= CMP_W'(2)) && (py >= CMP_W'(2)) &&
                    (px - CMP_W'(2) < w) && (py - CMP_W'(2) < h);
  assign rd_en    = (state == ST_SCAN) && scan_inb;
  assign rd_addr  = {IDX_W'(py - CMP_W'(2)), IDX_W'(px - CMP_W'(2))};

  cmro_code_store #(
    .ADDR_W (ADDR_W)
  ) u_code_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_code (new_code),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_code (rd_code)
  );

  assign cur_code    = (pend && pend_inb) ? rd_code : cmro_pkg::CODE_CLEAR;
  assign center_now  = (pend && pend_ctr) ? cur_code : center;
  assign near_now    = near || (cur_code != cmro_pkg::CODE_CLEAR);
  assign read_result = (center_now != cmro_pkg::CODE_CLEAR) ? center_now :
                       (near_now ? cmro_pkg::CODE_WHITE : cmro_pkg::CODE_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      xor_seen <= 1'b0;
      pend     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          pend <= 1'b0;
          if (load_take) begin
            xor_seen <= flag_next;
          end else if (read_take && !read_outside) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend <= 1'b1;
          if ((kx == 2'd2) && (ky == 2'd2)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          pend  <= 1'b0;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      rd_col <= req.col;
      rd_row <= req.row;
      kx     <= 2'd0;
      ky     <= 2'd0;
      center <= cmro_pkg::CODE_CLEAR;
      near   <= 1'b0;
    end else begin
      center <= center_now;
      near   <= near_now;
      if (state == ST_SCAN) begin
        pend_inb <= scan_inb;
        pend_ctr <= (kx == 2'd1) && (ky == 2'd1);
        if (kx == 2'd2) begin
          kx <= 2'd0;
          ky <= ky + 2'd1;
        end else begin
          kx <= kx + 2'd1;
        end
      end
    end
  end

  assign out_load = res_pend && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        res_pend  <= 1'b0;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (req_take && ((req.func == cmro_pkg::FUNC_LOAD) || read_outside)) begin
        res_pend <= 1'b1;
      end else if (state == ST_DRAIN) begin
        res_pend <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_take) begin
      res_code <= new_code;
      res_flag <= flag_next;
    end else if (read_take) begin
      res_code <= cmro_pkg::CODE_CLEAR;
      res_flag <= xor_seen;
    end else if (state == ST_DRAIN) begin
      res_code <= read_result;
      res_flag <= xor_seen;
    end
    if (out_load) begin
      out_code <= res_code;
      out_flag <= res_flag;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.red            = cmro_pkg::code_color(out_code);
  assign rsp.green          = cmro_pkg::code_color(out_code);
  assign rsp.blue           = cmro_pkg::code_color(out_code);
  assign rsp.alpha          = cmro_pkg::code_alpha(out_code);
  assign rsp.outline_needed = out_flag;

endmodule

// ===== rtl/cmro_checker.sv =====
// Port-level checker for the cursor outline core and its bind statement.
`include "cursor_mask_to_rgba_outline_core_defines.svh"

module cmro_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input cmro_pkg::byte_t red,
  input cmro_pkg::byte_t green,
  input cmro_pkg::byte_t blue,
  input cmro_pkg::byte_t alpha,
  input logic            outline_needed
);

  logic rsp_ok;

  assign rsp_ok = ((alpha == cmro_pkg::BYTE_NONE) && (red == cmro_pkg::BYTE_NONE) &&
                   (green == cmro_pkg::BYTE_NONE) && (blue == cmro_pkg::BYTE_NONE)) ||
                  ((alpha == cmro_pkg::BYTE_FULL) && (green == red) && (blue == red) &&
                   ((red == cmro_pkg::BYTE_NONE) || (red == cmro_pkg::BYTE_FULL)));

  `CMRO_ASSERT_SAME(a_idle_after_reset, clk, rst, $past(rst), !rsp_valid)
  `CMRO_ASSERT_NEXT(a_one_at_a_time, clk, rst, req_valid && req_ready, !req_ready)
  `CMRO_ASSERT_SAME(a_pixel_form, clk, rst, rsp_valid, rsp_ok)
  `CMRO_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(alpha) && $stable(red) && $stable(outline_needed))

endmodule

bind cursor_mask_to_rgba_outline_core cmro_checker u_cmro_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .red            (rsp.red),
  .green          (rsp.green),
  .blue           (rsp.blue),
  .alpha          (rsp.alpha),
  .outline_needed (rsp.outline_needed)
);
